/* rtl/wdc_pkg.sv */
// shared types and constants for the wake density pipeline
// no dependencies; every other rtl file imports this package
package wdc_pkg;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [45:0] SHIFT_CAP = 46'h3FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REGION_NONE   = 2'd0,
    REGION_SPHERE = 2'd1,
    REGION_CONE   = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    REG_MACH  = 3'd0,
    REG_SOUND = 3'd1,
    REG_TIME  = 3'd2,
    REG_GRAV  = 3'd3,
    REG_MASS  = 3'd4
  } reg_idx_t;

  // the Mach number and values derived from the configuration registers
  typedef struct packed {
    logic [31:0]  mach;
    logic [63:0]  ctime;
    logic [63:0]  msq;
    logic [63:0]  cs2;
    logic [63:0]  gm;
    logic [45:0]  vq;
    logic [127:0] ctsq;
  } consts_t;

  typedef struct packed {
    logic         v;
    logic [127:0] arg;
    logic         argpos;
    region_t      region;
  } root_in_t;

  typedef struct packed {
    logic        v;
    logic [63:0] root;
    logic        argpos;
    region_t     region;
  } root_out_t;

  typedef struct packed {
    logic        v;
    logic [31:0] density;
    region_t     region;
    logic        sat;
  } result_t;

endpackage

/* rtl/wdc_consts.sv */
// configuration-derived products, settled after a register write
// depends on wdc_pkg
module wdc_consts (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       mach,
  input  logic [31:0]       sound,
  input  logic [31:0]       etime,
  input  logic [31:0]       grav,
  input  logic [31:0]       mass,
  output wdc_pkg::consts_t  k
);
  import wdc_pkg::*;

  logic [63:0]  ctime, msq, cs2, gm;
  logic [63:0]  vp0, vp1, ct_ll, ct_lh, ct_hh;
  logic [45:0]  vq;
  logic [127:0] ctsq;
  logic [95:0]  vt;

  assign vt = {32'b0, vp0} + {vp1, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctime <= 64'd0;
      msq   <= 64'h1_0000_0000;
      cs2   <= 64'h1_0000_0000;
      gm    <= 64'h1_0000_0000;
      vp0   <= 64'd0;
      vp1   <= 64'd0;
      ct_ll <= 64'd0;
      ct_lh <= 64'd0;
      ct_hh <= 64'd0;
      vq    <= 46'd0;
      ctsq  <= 128'd0;
    end else begin
      ctime <= sound * etime;
      msq   <= mach * mach;
      cs2   <= sound * sound;
      gm    <= grav * mass;
      vp0   <= mach * ctime[31:0];
      vp1   <= mach * ctime[63:32];
      ct_ll <= ctime[31:0] * ctime[31:0];
      ct_lh <= ctime[31:0] * ctime[63:32];
      ct_hh <= ctime[63:32] * ctime[63:32];
      // shift of the wake axis, capped where it no longer matters
      vq    <= (|vt[95:78]) ? SHIFT_CAP : vt[77:32];
      ctsq  <= {64'b0, ct_ll} + {31'b0, ct_lh, 33'b0} + {ct_hh, 64'b0};
    end
  end

  always_comb begin
    k.mach  = mach;
    k.ctime = ctime;
    k.msq   = msq;
    k.cs2   = cs2;
    k.gm    = gm;
    k.vq    = vq;
    k.ctsq  = ctsq;
  end

endmodule

/* rtl/wdc_front.sv */
// geometry stages: squares, region tests and the root argument (7 stages)
// depends on wdc_pkg
module wdc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               take,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  wdc_pkg::consts_t   k,
  output wdc_pkg::root_in_t  o
);
  import wdc_pkg::*;

  logic [47:0] pz_w, vq_w, dpos, dneg;
  logic [31:0] ax, ay, az;

  logic        s1_v, s1_sneg;
  logic [31:0] s1_ax, s1_ay, s1_az;
  logic signed [31:0] s1_pz;
  logic [46:0] s1_us;

  logic        s2_v, s2_conep;
  logic [63:0] s2_x2, s2_y2, s2_z2, s2_ull;
  logic [46:0] s2_ulh;
  logic [29:0] s2_uhh;
  logic [62:0] s2_pzm;

  logic        s3_v, s3_cone;
  logic [63:0] s3_rad, s3_dist;
  logic [93:0] s3_ussq;

  logic        s4_v, s4_cone, s4_sph;
  logic [94:0] s4_lhs;
  logic [63:0] s4_ll, s4_lh, s4_hl, s4_hh;

  logic         s5_v, s5_cone, s5_sph;
  logic [94:0]  s5_lhs;
  logic [127:0] s5_rhs;

  logic         s6_v, s6_cone, s6_sph;
  logic [128:0] s6_diff;

  logic         s7_v, s7_argpos;
  logic [127:0] s7_arg;
  region_t      s7_region;

  logic argpos6;

  assign pz_w = {{16{pos_z[31]}}, pos_z};
  assign vq_w = {2'b0, k.vq};
  assign dpos = pz_w - vq_w;
  assign dneg = vq_w - pz_w;
  assign ax = pos_x[31] ? (~pos_x + 32'd1) : pos_x;
  assign ay = pos_y[31] ? (~pos_y + 32'd1) : pos_y;
  assign az = pos_z[31] ? (~pos_z + 32'd1) : pos_z;
  assign argpos6 = !s6_diff[128] && (|s6_diff[127:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
    end else if (adv) begin
      s1_v <= take;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax   <= ax;
      s1_ay   <= ay;
      s1_az   <= az;
      s1_pz   <= pos_z;
      s1_sneg <= dpos[47];
      s1_us   <= dpos[47] ? dneg[46:0] : dpos[46:0];

      s2_x2    <= s1_ax * s1_ax;
      s2_y2    <= s1_ay * s1_ay;
      s2_z2    <= s1_az * s1_az;
      s2_ull   <= s1_us[31:0] * s1_us[31:0];
      s2_ulh   <= s1_us[31:0] * s1_us[46:32];
      s2_uhh   <= s1_us[46:32] * s1_us[46:32];
      s2_pzm   <= s1_pz[30:0] * k.mach;
      s2_conep <= (k.mach > ONE_Q16) && s1_sneg && !s1_pz[31] && (s1_pz != 32'sd0);

      s3_rad  <= s2_x2 + s2_y2;
      s3_dist <= s2_x2 + s2_y2 + s2_z2;
      s3_ussq <= {30'b0, s2_ull} + {14'b0, s2_ulh, 33'b0} + {s2_uhh, 64'b0};
      // behind the sphere along the axis: z*M > c*t
      s3_cone <= s2_conep && ({1'b0, s2_pzm} > k.ctime);

      s4_lhs  <= {1'b0, s3_ussq} + {31'b0, s3_rad};
      s4_ll   <= s3_rad[31:0] * k.msq[31:0];
      s4_lh   <= s3_rad[31:0] * k.msq[63:32];
      s4_hl   <= s3_rad[63:32] * k.msq[31:0];
      s4_hh   <= s3_rad[63:32] * k.msq[63:32];
      s4_sph  <= {s3_dist, 32'b0} < k.ctsq;
      s4_cone <= s3_cone;

      s5_lhs  <= s4_lhs;
      s5_rhs  <= {64'b0, s4_ll} + {32'b0, s4_lh, 32'b0} + {32'b0, s4_hl, 32'b0}
                 + {s4_hh, 64'b0};
      s5_sph  <= s4_sph;
      s5_cone <= s4_cone;

      s6_diff <= {2'b0, s5_lhs, 32'b0} - {1'b0, s5_rhs};
      s6_sph  <= s5_sph;
      s6_cone <= s5_cone;

      s7_argpos <= argpos6;
      s7_arg    <= argpos6 ? s6_diff[127:0] : 128'd0;
      if (s6_sph) begin
        s7_region <= REGION_SPHERE;
      end else if (s6_cone && argpos6) begin
        s7_region <= REGION_CONE;
      end else begin
        s7_region <= REGION_NONE;
      end
    end
  end

  always_comb begin
    o.v      = s7_v;
    o.arg    = s7_arg;
    o.argpos = s7_argpos;
    o.region = s7_region;
  end

endmodule

/* rtl/wdc_sqrt.sv */
// floor square root of the 128-bit argument, two argument bits per stage
// 64 register stages; depends on wdc_pkg
module wdc_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  wdc_pkg::root_in_t  i,
  output wdc_pkg::root_out_t o
);
  import wdc_pkg::*;

  localparam int Steps = 64;

  logic         p_v      [0:Steps];
  logic [67:0]  p_rem    [0:Steps];
  logic [63:0]  p_root   [0:Steps];
  logic [127:0] p_bits   [0:Steps];
  logic         p_argpos [0:Steps];
  region_t      p_region [0:Steps];

  assign p_v[0]      = i.v;
  assign p_rem[0]    = 68'd0;
  assign p_root[0]   = 64'd0;
  assign p_bits[0]   = i.arg;
  assign p_argpos[0] = i.argpos;
  assign p_region[0] = i.region;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [67:0] remsh, trial;
    logic        ge;

    assign remsh = {p_rem[s][65:0], p_bits[s][127:126]};
    assign trial = {2'b0, p_root[s], 2'b01};
    assign ge    = remsh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        p_v[s+1] <= 1'b0;
      end else if (adv) begin
        p_v[s+1] <= p_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p_rem[s+1]    <= ge ? (remsh - trial) : remsh;
        p_root[s+1]   <= {p_root[s][62:0], ge};
        p_bits[s+1]   <= {p_bits[s][125:0], 2'b00};
        p_argpos[s+1] <= p_argpos[s];
        p_region[s+1] <= p_region[s];
      end
    end
  end

  always_comb begin
    o.v      = p_v[Steps];
    o.root   = p_root[Steps];
    o.argpos = p_argpos[Steps];
    o.region = p_region[Steps];
  end

endmodule

/* rtl/wdc_div.sv */
// divisor build (c^2 * root), overflow test and 32 quotient-bit stages
// 35 register stages; depends on wdc_pkg
module wdc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  wdc_pkg::root_out_t i,
  input  wdc_pkg::consts_t   k,
  output wdc_pkg::result_t   o
);
  import wdc_pkg::*;

  localparam int Qbits = 32;

  logic        m1_v, m1_bad;
  region_t     m1_region;
  logic [63:0] m1_ll, m1_lh, m1_hl, m1_hh;

  logic         m2_v, m2_bad;
  region_t      m2_region;
  logic [127:0] m2_d;
  logic [112:0] m2_num;

  logic         q_v    [0:Qbits];
  logic         q_bad  [0:Qbits];
  region_t      q_reg  [0:Qbits];
  logic [127:0] q_d    [0:Qbits];
  logic [112:0] q_rem  [0:Qbits];
  logic [31:0]  q_q    [0:Qbits];

  logic fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v   <= 1'b0;
      m2_v   <= 1'b0;
      q_v[0] <= 1'b0;
    end else if (adv) begin
      m1_v   <= i.v;
      m2_v   <= m1_v;
      q_v[0] <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_bad    <= !i.argpos || (i.root == 64'd0) || (k.cs2 == 64'd0);
      m1_region <= i.region;
      m1_ll     <= k.cs2[31:0] * i.root[31:0];
      m1_lh     <= k.cs2[31:0] * i.root[63:32];
      m1_hl     <= k.cs2[63:32] * i.root[31:0];
      m1_hh     <= k.cs2[63:32] * i.root[63:32];

      m2_bad    <= m1_bad;
      m2_region <= m1_region;
      m2_d      <= {64'b0, m1_ll} + {32'b0, m1_lh, 32'b0} + {32'b0, m1_hl, 32'b0}
                   + {m1_hh, 64'b0};
      // the cone counts twice
      m2_num    <= (m1_region == REGION_CONE) ? {k.gm, 49'b0} : {1'b0, k.gm, 48'b0};

      // quotient of 2^32 or more overflows Q16.16
      q_bad[0] <= m2_bad || ({47'b0, m2_num} >= {m2_d, 32'b0});
      q_reg[0] <= m2_region;
      q_d[0]   <= m2_d;
      q_rem[0] <= m2_num;
      q_q[0]   <= 32'd0;
    end
  end

  for (genvar j = 0; j < Qbits; j++) begin : g_qbit
    logic [159:0] t;
    logic         ge;
    logic [31:0]  qn;

    assign t  = {32'b0, q_d[j]} << (Qbits - 1 - j);
    assign ge = {47'b0, q_rem[j]} >= t;

    always_comb begin
      qn = q_q[j];
      qn[Qbits-1-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[j+1] <= 1'b0;
      end else if (adv) begin
        q_v[j+1] <= q_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_rem[j+1] <= ge ? (q_rem[j] - t[112:0]) : q_rem[j];
        q_q[j+1]   <= qn;
        q_d[j+1]   <= q_d[j];
        q_bad[j+1] <= q_bad[j];
        q_reg[j+1] <= q_reg[j];
      end
    end
  end

  assign fail = q_reg[Qbits] != REGION_NONE && q_bad[Qbits];

  always_comb begin
    o.v      = q_v[Qbits];
    o.region = q_reg[Qbits];
    o.sat    = fail;
    if (q_reg[Qbits] == REGION_NONE) begin
      o.density = 32'd0;
    end else if (fail) begin
      o.density = {32{1'b1}};
    end else begin
      o.density = q_q[Qbits];
    end
  end

endmodule

/* rtl/wdc_outq.sv */
// two-entry output queue; holds the pipeline while both entries are full
// depends on wdc_pkg
module wdc_outq (
  input  logic             clk,
  input  logic             rst,
  input  wdc_pkg::result_t i,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      density_factor,
  output logic [1:0]       region,
  output logic             saturated
);
  import wdc_pkg::*;

  logic [1:0]  count;
  logic        head, tail;
  logic [34:0] mem [0:1];
  logic        push, pop;

  assign adv       = count != 2'd2;
  assign push      = i.v && adv;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && !out_stall;

  assign density_factor = mem[head][34:3];
  assign region         = mem[head][2:1];
  assign saturated      = mem[head][0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 1'b0;
      tail  <= 1'b0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= {i.density, i.region, i.sat};
    end
  end

endmodule

/* rtl/wake_density_cartesian_top.sv */
// Wake density enhancement of a perturber moving through gas, one sample
// point (pos_x, pos_y, pos_z, signed Q16.16) per item on the input channel.
// Each item gives one result: density_factor (Q16.16), region and saturated.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. Mach number, sound speed, time, G and mass are set over the APB
// port (byte addresses 0, 4, 8, 12, 16); the user must set them only while
// no item is in flight, as the block does not enforce this. From input
// acceptance to out_valid an item passes 7 geometry stages, 64 square-root
// stages (two argument bits each), 35 stages for the divisor product and
// the 32 quotient bits, and the output queue. One item is taken per cycle
// while in_stall is low; it is high while products settle after a write.
// Reset restores the register defaults and empties the pipeline and queue.
// When the receiver stalls, results collect in a two-entry output queue;
// once it is full the whole pipeline holds and in_stall goes high, and
// nothing in flight is lost or repeated.
// depends on wdc_pkg, wdc_consts, wdc_front, wdc_sqrt, wdc_div, wdc_outq
module wake_density_cartesian_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        density_factor,
  output logic [1:0]         region,
  output logic               saturated
);
  import wdc_pkg::*;

  localparam logic [1:0] SETTLE = 2'd3;

  logic [31:0] mach, sound, etime, grav, mass;
  logic [1:0]  busy;
  logic        wr, adv, take;
  reg_idx_t    idx;

  consts_t   k;
  root_in_t  f2s;
  root_out_t s2d;
  result_t   d2q;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite && pready;
  assign idx      = reg_idx_t'(paddr[4:2]);
  assign in_stall = !(adv && busy == 2'd0);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mach  <= ONE_Q16;
      sound <= ONE_Q16;
      etime <= 32'd0;
      grav  <= ONE_Q16;
      mass  <= ONE_Q16;
      busy  <= 2'd0;
    end else begin
      if (wr) begin
        busy <= SETTLE;
        case (idx)
          REG_MACH:  mach  <= pwdata;
          REG_SOUND: sound <= pwdata;
          REG_TIME:  etime <= pwdata;
          REG_GRAV:  grav  <= pwdata;
          REG_MASS:  mass  <= pwdata;
          default: ;
        endcase
      end else if (busy != 2'd0) begin
        busy <= busy - 2'd1;
      end
    end
  end

  always_comb begin
    case (idx)
      REG_MACH:  prdata = mach;
      REG_SOUND: prdata = sound;
      REG_TIME:  prdata = etime;
      REG_GRAV:  prdata = grav;
      REG_MASS:  prdata = mass;
      default:   prdata = 32'd0;
    endcase
  end

  wdc_consts u_consts (
    .clk   (clk),
    .rst   (rst),
    .mach  (mach),
    .sound (sound),
    .etime (etime),
    .grav  (grav),
    .mass  (mass),
    .k     (k)
  );

  wdc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .take  (take),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .pos_z (pos_z),
    .k     (k),
    .o     (f2s)
  );

  wdc_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .i   (f2s),
    .o   (s2d)
  );

  wdc_div u_div (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .i   (s2d),
    .k   (k),
    .o   (d2q)
  );

  wdc_outq u_outq (
    .clk            (clk),
    .rst            (rst),
    .i              (d2q),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .density_factor (density_factor),
    .region         (region),
    .saturated      (saturated)
  );

endmodule

/* tb/sv/wake_density_cartesian_top_tb.sv */
`timescale 1ns / 1ps
// testbench for wake_density_cartesian_top: drives sample points and APB register writes,
// predicts density, region and saturation per point and checks every result in order
// depends on wdc_pkg and the rtl of wake_density_cartesian_top
module wake_density_cartesian_top_tb;
  import wdc_pkg::*;

  typedef struct {
    logic [31:0] density;
    region_t     region;
    logic        sat;
  } wake_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] density_factor;
  logic [1:0] region;
  logic saturated;

  logic [31:0] cfg_mach, cfg_sound, cfg_time, cfg_grav, cfg_mass;
  wake_t pending_wakes[$];
  int mismatches = 0;
  int idle_pct = 0, stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  wake_density_cartesian_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wake_t predict_wake(logic signed [31:0] x, y, z);
    logic signed [63:0] sx, sy, sz, sv;
    logic [63:0] ax, ay, az, radsq, distsq, ctime, vq, us, msq, cs2, gm, root, cand;
    logic [127:0] vt, lhs, rhs, arg, num, q;
    logic argpos;
    wake_t w;
    sx = x; sy = y; sz = z;
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    az = sz < 0 ? -sz : sz;
    radsq = ax * ax + ay * ay;
    distsq = radsq + az * az;
    ctime = 64'(cfg_sound) * 64'(cfg_time);
    vt = 128'(cfg_mach) * 128'(ctime);
    vq = (vt[127:64] >= 64'd16384) ? 64'(SHIFT_CAP) : vt[95:32];
    sv = sz - $signed(vq);
    us = sv < 0 ? -sv : sv;
    lhs = ((128'(us) * 128'(us)) << 32) + (128'(radsq) << 32);
    msq = 64'(cfg_mach) * 64'(cfg_mach);
    rhs = 128'(radsq) * 128'(msq);
    argpos = lhs > rhs;
    arg = argpos ? lhs - rhs : 128'd0;
    w.density = '0;
    w.sat = 1'b0;
    w.region = REGION_NONE;
    if ((128'(distsq) << 32) < 128'(ctime) * 128'(ctime))
      w.region = REGION_SPHERE;
    else if (cfg_mach > ONE_Q16 && sv < 0 && argpos && sz > 0 &&
             64'(unsigned'(z)) * 64'(cfg_mach) > ctime)
      w.region = REGION_CONE;
    if (w.region != REGION_NONE) begin
      cs2 = 64'(cfg_sound) * 64'(cfg_sound);
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= arg) root = cand;
      end
      if (!argpos || root == 0 || cs2 == 0) begin
        w.density = '1;
        w.sat = 1'b1;
      end else begin
        gm = 64'(cfg_grav) * 64'(cfg_mass);
        num = 128'(gm) << (w.region == REGION_CONE ? 49 : 48);
        q = (num / 128'(cs2)) / 128'(root);
        if (q > 128'h0FFFF_FFFF) begin
          w.density = '1;
          w.sat = 1'b1;
        end else begin
          w.density = q[31:0];
        end
      end
    end
    return w;
  endfunction

  // called just after a rising edge; leaves in_valid high
  task automatic send_point(logic signed [31:0] x, y, z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    pending_wakes.push_back(predict_wake(x, y, z));
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_wakes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MACH:  cfg_mach = val;
      REG_SOUND: cfg_sound = val;
      REG_TIME:  cfg_time = val;
      REG_GRAV:  cfg_grav = val;
      REG_MASS:  cfg_mass = val;
      default: ;
    endcase
  endtask

  task automatic set_wake(logic [31:0] m, c, t, g, ms);
    drain_results();
    repeat (120) @(posedge clk);
    write_reg(REG_MACH, m);
    write_reg(REG_SOUND, c);
    write_reg(REG_TIME, t);
    write_reg(REG_GRAV, g);
    write_reg(REG_MASS, ms);
  endtask

  // coordinates scaled to the wake size so that all regions get hit
  function automatic logic [31:0] pick_coord();
    logic [63:0] reach;
    logic [31:0] span;
    reach = (64'(cfg_mach) * 64'(cfg_sound) >> 16) * 64'(cfg_time) >> 15;
    span = reach > 64'h3FFF_FFFF ? 32'h3FFF_FFFF :
           reach < 64'h1_0000 ? 32'h1_0000 : reach[31:0];
    if ($urandom_range(99) < 15) return $urandom;
    return $urandom_range(span) - (span >> 1) + ($urandom_range(1) ? 0 : span >> 2);
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic random_wake();
    case ($urandom_range(5))
      0: set_wake('1, '1, '1, '1, '1);
      1: set_wake('0, '0, '0, '0, '0);
      default: set_wake($urandom_range(32'h8_0000), $urandom_range(32'h4_0000, 32'h4000),
                        $urandom_range(32'h10_0000), $urandom_range(32'h40_0000),
                        $urandom_range(32'h40_0000));
    endcase
  endtask

  task automatic test_directed();
    logic signed [31:0] edges[6];
    edges = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh1_0000, -32'sh1_0000, 32'sh3_0000};
    for (int i = 0; i < 6; i++) send_point(edges[i], edges[5 - i], edges[(i + 2) % 6]);
    set_wake(32'h2_0000, 32'h1_0000, 32'h4_0000, 32'h1_0000, 32'h1_0000);
    send_point(0, 0, 0);                        // sphere center
    send_point(32'sh1_0000, 0, 32'sh2_0000);    // inside sphere
    send_point(32'sh1_0000, 0, 32'sh6_0000);    // supersonic cone
    send_point(32'sh1_0000, 0, 32'sh9_0000);    // ahead of perturber
    send_point(32'sh8_0000, 0, 32'sh6_0000);    // beside the cone
    send_point(0, 0, 32'sh8_0000);              // on the perturber, zero root
    send_point(0, 0, -32'sh8_0000);
    set_wake(32'h1_0000, 32'h0, 32'h4_0000, 32'h1_0000, 32'h1_0000);    // no sound speed
    send_point(0, 0, 0);
    send_point(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
    set_wake(32'h3_0000, 32'h1_0000, 32'h2_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(0, 32'sh100, 32'sh1_0000);       // overflowing density
    send_point(32'sh100, 0, 32'sh5_0000);
    send_point(32'sh4000, 32'sh4000, 32'sh4_0000);
    set_wake(32'h8000, 32'h2_0000, 32'h3_0000, 32'h2_0000, 32'h8000);   // subsonic
    send_point(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
    send_point(0, 0, 32'sh5_0000);
  endtask

  task automatic test_random_phases();
    int pcts[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{11, 11}};
    for (int p = 0; p < 8; p++) begin
      random_wake();
      idle_pct = pcts[p % 4][0];
      stall_pct = pcts[p % 4][1];
      random_points(40);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // more items than the pipeline holds, so the input stalls during the hold
  task automatic test_backpressure();
    random_wake();
    fork
      begin
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    random_points(130);
  endtask

  task automatic test_pause();
    random_points(20);
    drain_results();
    random_points(20);
  endtask

  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);

  always @(negedge clk) begin
    wake_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_wakes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: density %h region %0d sat %b",
                                       density_factor, region, saturated);
      end else begin
        want = pending_wakes.pop_front();
        if (density_factor !== want.density || region !== want.region ||
            saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%0d/%b got %h/%0d/%b", want.density,
                     want.region, want.sat, density_factor, region, saturated);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cfg_mach = ONE_Q16;
    cfg_sound = ONE_Q16;
    cfg_time = '0;
    cfg_grav = ONE_Q16;
    cfg_mass = ONE_Q16;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    test_pause();
    drain_results();
    repeat (150) @(posedge clk);
    mismatches += pending_wakes.size();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

/* wake_density_cartesian_top.f */
rtl/wdc_pkg.sv
rtl/wdc_consts.sv
rtl/wdc_front.sv
rtl/wdc_sqrt.sv
rtl/wdc_div.sv
rtl/wdc_outq.sv
rtl/wake_density_cartesian_top.sv
tb/sv/wake_density_cartesian_top_tb.sv
